/* hdl/glyph_run_layout_core_defines.svh */
// assertion macros for the glyph run layout core checker
`ifndef GLYPH_RUN_LAYOUT_CORE_DEFINES_SVH
`define GLYPH_RUN_LAYOUT_CORE_DEFINES_SVH

// checked only outside reset
`define GRL_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define GRL_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/grl_pkg.sv */
// shared constants, codes and types of the glyph run layout core
`timescale 1ns / 1ps
`default_nettype none
package grl_pkg;

  localparam int GLYPH_COUNT      = 256;
  localparam int ATLAS_COORD_BITS = 12;
  localparam int INDEX_BITS       = $clog2(GLYPH_COUNT);
  localparam int CODE_BITS        = 8;
  localparam int X_BITS           = ATLAS_COORD_BITS + 1;

  localparam int PEN_BITS   = 15;
  localparam int LINE_BITS  = 16;
  localparam int ADV_BITS   = 9;
  localparam int OFS_BITS   = 12;
  localparam int PROD_BITS  = 27;

  localparam logic [PEN_BITS-1:0]  PEN_MAX  = '1;
  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

  // floor(x / 5) for x below 2048 as (x * 52429) >> 18
  localparam logic [15:0] DIV5_MUL   = 16'd52429;
  localparam int          DIV5_SHIFT = 18;

  localparam logic [CODE_BITS-1:0] NEWLINE_CODE = 8'd10;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_PLACE = 2'd1;
  localparam logic [1:0] MODE_END   = 2'd2;

  localparam logic [1:0] OP_GLYPH   = 2'd0;
  localparam logic [1:0] OP_NEWLINE = 2'd1;
  localparam logic [1:0] OP_END     = 2'd2;

  localparam logic KIND_PLACE  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic CFG_BASELINE_ROW = 1'b0;
  localparam logic CFG_TOP_OFFSET   = 1'b1;

  localparam logic [7:0] BASELINE_ROW_RESET = 8'd35;
  localparam logic [7:0] TOP_OFFSET_RESET   = 8'd5;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [X_BITS-1:0]           x;
    logic [ATLAS_COORD_BITS-1:0] y;
    logic [7:0]                  w;
    logic [7:0]                  h;
    logic [8:0]                  b;
    logic [ADV_BITS-1:0]         adv;
  } entry_t;

  localparam entry_t ENTRY_ABSENT = '{x: '1, y: '0, w: '0, h: '0, b: '0, adv: '0};

  typedef struct packed {
    logic [1:0]          op;
    logic [12:0]         src_x;
    logic [11:0]         src_y;
    logic [7:0]          w;
    logic [7:0]          h;
    logic [ADV_BITS-1:0] adv;
    logic [OFS_BITS-1:0] ofs;
    logic [7:0]          nl_h;
  } work_t;

endpackage
`default_nettype wire

/* hdl/grl_queue.sv */
// short request queue between the front and back parts
`timescale 1ns / 1ps
`default_nettype none
module grl_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire grl_pkg::work_t push_item,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output grl_pkg::work_t      pop_item
);

  grl_pkg::work_t                slots [grl_pkg::QUEUE_DEPTH];
  logic [grl_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [grl_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [grl_pkg::QPTR_BITS:0]   count;
  logic                          do_push;
  logic                          do_pop;

  assign push_ready = count != (grl_pkg::QPTR_BITS+1)'(grl_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_item;
  end

endmodule
`default_nettype wire

/* hdl/grl_front.sv */
// front part: glyph table, request intake and classification
`timescale 1ns / 1ps
`default_nettype none
module grl_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         mode,
  input  wire logic [7:0]         char_code,
  input  wire logic signed [12:0] atlas_x,
  input  wire logic [11:0]        atlas_y,
  input  wire logic [7:0]         glyph_width,
  input  wire logic [7:0]         glyph_height,
  input  wire logic signed [8:0]  glyph_baseline,
  input  wire logic [7:0]         baseline_row,
  input  wire logic [7:0]         top_offset,
  output logic                    q_valid,
  input  wire logic               q_ready,
  output grl_pkg::work_t          q_item
);

  grl_pkg::entry_t                glyph_mem [grl_pkg::GLYPH_COUNT];
  logic [grl_pkg::GLYPH_COUNT-1:0] entry_valid;
  logic [7:0]                     nl_h;

  logic                           f1_valid;
  logic [1:0]                     f1_mode;
  logic [7:0]                     f1_code;
  logic                           f1_in_range;
  logic [7:0]                     f1_nl_h;
  logic                           rd_valid;
  grl_pkg::entry_t                rd_entry;

  logic                           in_accept;
  logic                           in_range;
  logic [grl_pkg::INDEX_BITS-1:0] idx;
  logic                           do_load;
  grl_pkg::entry_t                new_entry;
  logic [10:0]                    w6;
  logic [grl_pkg::PROD_BITS-1:0]  adv_prod;

  grl_pkg::entry_t                ent;
  logic                           needs_push;
  logic [1:0]                     op;
  logic [grl_pkg::OFS_BITS-1:0]   b_ext;

  assign in_range  = {1'b0, char_code} < (grl_pkg::CODE_BITS+1)'(grl_pkg::GLYPH_COUNT);
  assign idx       = char_code[grl_pkg::INDEX_BITS-1:0];
  assign in_accept = in_valid && in_ready;
  assign do_load   = in_accept && (mode == grl_pkg::MODE_LOAD) && in_range;

  // advance of floor(6w/5), worked out once at load time
  assign w6       = 11'({glyph_width, 2'b00}) + 11'({glyph_width, 1'b0});
  assign adv_prod = grl_pkg::PROD_BITS'(w6) * grl_pkg::PROD_BITS'(grl_pkg::DIV5_MUL);

  always_comb begin
    new_entry.x   = grl_pkg::X_BITS'(atlas_x);
    new_entry.y   = grl_pkg::ATLAS_COORD_BITS'(atlas_y);
    new_entry.w   = glyph_width;
    new_entry.h   = glyph_height;
    new_entry.b   = glyph_baseline;
    new_entry.adv = adv_prod[grl_pkg::DIV5_SHIFT +: grl_pkg::ADV_BITS];
  end

  always_ff @(posedge clk) begin
    if (do_load) glyph_mem[idx] <= new_entry;
    if (in_accept) rd_entry <= glyph_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      nl_h        <= '0;
      f1_valid    <= 1'b0;
    end else begin
      if (do_load) entry_valid[idx] <= 1'b1;
      if (do_load && char_code == grl_pkg::NEWLINE_CODE) nl_h <= glyph_height;
      if (in_ready) f1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      f1_mode     <= mode;
      f1_code     <= char_code;
      f1_in_range <= in_range;
      f1_nl_h     <= nl_h;
      rd_valid    <= entry_valid[idx];
    end
  end

  assign ent = (rd_valid && f1_in_range) ? rd_entry : grl_pkg::ENTRY_ABSENT;

  always_comb begin
    needs_push = 1'b0;
    op         = grl_pkg::OP_GLYPH;
    unique case (f1_mode)
      grl_pkg::MODE_PLACE: begin
        needs_push = 1'b1;
        op = (f1_code == grl_pkg::NEWLINE_CODE) ? grl_pkg::OP_NEWLINE : grl_pkg::OP_GLYPH;
      end
      grl_pkg::MODE_END: begin
        needs_push = 1'b1;
        op         = grl_pkg::OP_END;
      end
      default: begin
        needs_push = 1'b0;
        op         = grl_pkg::OP_GLYPH;
      end
    endcase
  end

  assign b_ext = {{(grl_pkg::OFS_BITS-9){ent.b[8]}}, ent.b};

  always_comb begin
    q_item.op    = op;
    q_item.src_x = 13'(signed'(ent.x));
    q_item.src_y = 12'(ent.y);
    q_item.w     = ent.w;
    q_item.h     = ent.h;
    q_item.adv   = ent.adv;
    q_item.ofs   = grl_pkg::OFS_BITS'(baseline_row) + grl_pkg::OFS_BITS'(top_offset)
                 - grl_pkg::OFS_BITS'(ent.h) - b_ext;
    q_item.nl_h  = f1_nl_h;
  end

  assign q_valid  = f1_valid && needs_push;
  assign in_ready = !f1_valid || !needs_push || q_ready;

endmodule
`default_nettype wire

/* hdl/grl_back.sv */
// back part: pen state, saturation and the registered result
`timescale 1ns / 1ps
`default_nettype none
module grl_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  output logic                q_ready,
  input  wire grl_pkg::work_t q_item,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic                kind,
  output logic signed [12:0]  src_x,
  output logic [11:0]         src_y,
  output logic [7:0]          box_width,
  output logic [7:0]          box_height,
  output logic [14:0]         dst_x,
  output logic signed [16:0]  dst_y,
  output logic [14:0]         total_width,
  output logic [15:0]         total_height
);

  logic [grl_pkg::PEN_BITS-1:0]  pen_x;
  logic [grl_pkg::PEN_BITS-1:0]  pen_y;
  logic [grl_pkg::PEN_BITS-1:0]  widest_line;
  logic [grl_pkg::LINE_BITS-1:0] line_count;

  logic                          take;
  logic [grl_pkg::PEN_BITS:0]    px_sum;
  logic [grl_pkg::PEN_BITS:0]    py_sum;
  logic [grl_pkg::PEN_BITS-1:0]  pen_x_next;
  logic [grl_pkg::PEN_BITS-1:0]  pen_y_next;
  logic [grl_pkg::PEN_BITS-1:0]  wmax;
  logic [grl_pkg::LINE_BITS-1:0] line_count_next;
  logic [23:0]                   th;
  logic [15:0]                   th_sat;
  logic [16:0]                   dst_y_next;

  assign q_ready = !out_valid || out_ready;
  assign take    = q_valid && q_ready;

  assign px_sum     = {1'b0, pen_x} + (grl_pkg::PEN_BITS+1)'(q_item.adv);
  assign pen_x_next = px_sum[grl_pkg::PEN_BITS] ? grl_pkg::PEN_MAX
                                                : px_sum[grl_pkg::PEN_BITS-1:0];
  assign py_sum     = {1'b0, pen_y} + (grl_pkg::PEN_BITS+1)'(q_item.nl_h);
  assign pen_y_next = py_sum[grl_pkg::PEN_BITS] ? grl_pkg::PEN_MAX
                                                : py_sum[grl_pkg::PEN_BITS-1:0];
  assign wmax       = (pen_x > widest_line) ? pen_x : widest_line;
  assign line_count_next = (line_count == grl_pkg::LINE_MAX) ? line_count
                                                             : line_count + 1'b1;
  assign th     = 24'(line_count) * 24'(q_item.nl_h);
  assign th_sat = (|th[23:16]) ? 16'hffff : th[15:0];
  assign dst_y_next = 17'(pen_y) + {{(17-grl_pkg::OFS_BITS){q_item.ofs[grl_pkg::OFS_BITS-1]}},
                                    q_item.ofs};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      pen_x       <= '0;
      pen_y       <= '0;
      widest_line <= '0;
      line_count  <= grl_pkg::LINE_BITS'(1);
    end else begin
      if (take) begin
        unique case (q_item.op)
          grl_pkg::OP_GLYPH: begin
            out_valid <= 1'b1;
            pen_x     <= pen_x_next;
          end
          grl_pkg::OP_NEWLINE: begin
            out_valid   <= 1'b0;
            widest_line <= wmax;
            pen_x       <= '0;
            pen_y       <= pen_y_next;
            line_count  <= line_count_next;
          end
          grl_pkg::OP_END: begin
            out_valid   <= 1'b1;
            pen_x       <= '0;
            pen_y       <= '0;
            widest_line <= '0;
            line_count  <= grl_pkg::LINE_BITS'(1);
          end
          default: begin
            out_valid <= 1'b0;
          end
        endcase
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      case (q_item.op)
        grl_pkg::OP_GLYPH: begin
          kind         <= grl_pkg::KIND_PLACE;
          src_x        <= q_item.src_x;
          src_y        <= q_item.src_y;
          box_width    <= q_item.w;
          box_height   <= q_item.h;
          dst_x        <= pen_x;
          dst_y        <= dst_y_next;
          total_width  <= '0;
          total_height <= '0;
        end
        grl_pkg::OP_END: begin
          kind         <= grl_pkg::KIND_REPORT;
          src_x        <= '0;
          src_y        <= '0;
          box_width    <= '0;
          box_height   <= '0;
          dst_x        <= '0;
          dst_y        <= '0;
          total_width  <= wmax;
          total_height <= th_sat;
        end
        default: begin
          kind         <= grl_pkg::KIND_PLACE;
          src_x        <= '0;
          src_y        <= '0;
          box_width    <= '0;
          box_height   <= '0;
          dst_x        <= '0;
          dst_y        <= '0;
          total_width  <= '0;
          total_height <= '0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/glyph_run_layout_core.sv */
// top level of the glyph run layout core: configuration registers and wiring
// Takes one request per clock cycle while results are taken: load a glyph entry, place a
// character or end the string. A placed character gives its atlas rectangle and destination
// corner; a newline moves the pen and gives nothing; an end gives the widest line and the
// string height. A result passes through the front register, the request queue and the
// registered output of the back part; the single-port glyph table read and the pen update
// each handle one request per cycle. The table reads as empty (column -1, all else zero)
// after reset through per-entry valid bits, so no clearing pass is needed. Configuration
// writes are accepted in any cycle but must only be made while the core is idle.
`timescale 1ns / 1ps
`default_nettype none
module glyph_run_layout_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [7:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         mode,
  input  wire logic [7:0]         char_code,
  input  wire logic signed [12:0] atlas_x,
  input  wire logic [11:0]        atlas_y,
  input  wire logic [7:0]         glyph_width,
  input  wire logic [7:0]         glyph_height,
  input  wire logic signed [8:0]  glyph_baseline,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    kind,
  output logic signed [12:0]      src_x,
  output logic [11:0]             src_y,
  output logic [7:0]              box_width,
  output logic [7:0]              box_height,
  output logic [14:0]             dst_x,
  output logic signed [16:0]      dst_y,
  output logic [14:0]             total_width,
  output logic [15:0]             total_height
);

  logic [7:0]     baseline_row;
  logic [7:0]     top_offset;
  logic           fq_valid;
  logic           fq_ready;
  grl_pkg::work_t fq_item;
  logic           qb_valid;
  logic           qb_ready;
  grl_pkg::work_t qb_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_row <= grl_pkg::BASELINE_ROW_RESET;
      top_offset   <= grl_pkg::TOP_OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        grl_pkg::CFG_BASELINE_ROW: baseline_row <= cfg_data;
        grl_pkg::CFG_TOP_OFFSET:   top_offset   <= cfg_data;
        default:                   baseline_row <= baseline_row;
      endcase
    end
  end

  grl_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .char_code      (char_code),
    .atlas_x        (atlas_x),
    .atlas_y        (atlas_y),
    .glyph_width    (glyph_width),
    .glyph_height   (glyph_height),
    .glyph_baseline (glyph_baseline),
    .baseline_row   (baseline_row),
    .top_offset     (top_offset),
    .q_valid        (fq_valid),
    .q_ready        (fq_ready),
    .q_item         (fq_item)
  );

  grl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_item   (qb_item)
  );

  grl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (qb_valid),
    .q_ready      (qb_ready),
    .q_item       (qb_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .src_x        (src_x),
    .src_y        (src_y),
    .box_width    (box_width),
    .box_height   (box_height),
    .dst_x        (dst_x),
    .dst_y        (dst_y),
    .total_width  (total_width),
    .total_height (total_height)
  );

endmodule
`default_nettype wire

/* hdl/grl_checker.sv */
// port-level checker for the glyph run layout core, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "glyph_run_layout_core_defines.svh"
module grl_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               cfg_valid,
  input wire logic               cfg_ready,
  input wire logic               cfg_index,
  input wire logic [7:0]         cfg_data,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic [1:0]         mode,
  input wire logic [7:0]         char_code,
  input wire logic signed [12:0] atlas_x,
  input wire logic [11:0]        atlas_y,
  input wire logic [7:0]         glyph_width,
  input wire logic [7:0]         glyph_height,
  input wire logic signed [8:0]  glyph_baseline,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               kind,
  input wire logic signed [12:0] src_x,
  input wire logic [11:0]        src_y,
  input wire logic [7:0]         box_width,
  input wire logic [7:0]         box_height,
  input wire logic [14:0]        dst_x,
  input wire logic signed [16:0] dst_y,
  input wire logic [14:0]        total_width,
  input wire logic [15:0]        total_height
);

  `GRL_ASSERT_ALWAYS(a_reset_clears_result, clk, rst |=> !out_valid, "result valid after reset")

  `GRL_ASSERT(a_result_holds, clk, rst, out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(dst_x) && $stable(dst_y) && $stable(total_height), "stalled result changed")

  `GRL_ASSERT(a_report_fields, clk, rst, out_valid && kind == grl_pkg::KIND_REPORT |-> src_x == 13'sd0 && src_y == 12'd0 && box_width == 8'd0 && box_height == 8'd0 && dst_x == 15'd0 && dst_y == 17'sd0, "size report carries placement fields")

  `GRL_ASSERT(a_place_fields, clk, rst, out_valid && kind == grl_pkg::KIND_PLACE |-> total_width == 15'd0 && total_height == 16'd0, "placement carries size fields")

endmodule

bind glyph_run_layout_core grl_checker u_grl_checker (.*);
`default_nettype wire
